[hw/rtl/fragment_reassembly_tracker_unit_defines.svh]
// ----------------------------------------------------------------------------
// Fragment reassembly tracker: assertion macros
// Shared helpers for the concurrent checks of the reassembly tracker.
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_REASSEMBLY_TRACKER_UNIT_DEFINES_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FRT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/frt_pkg.sv]
// ----------------------------------------------------------------------------
// Fragment reassembly tracker package
// Field widths, payload and record types, command and status codes.
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int unsigned FRT_SLOTS     = 8;
  localparam int unsigned FRT_MAX_FRAGS = 16;

  localparam int unsigned FRT_ID_W    = 16;
  localparam int unsigned FRT_IDX_W   = 4;
  localparam int unsigned FRT_MASK_W  = 16;
  localparam int unsigned FRT_FLEN_W  = 11;
  localparam int unsigned FRT_LEN_W   = 16;
  localparam int unsigned FRT_TIME_W  = 32;
  localparam int unsigned FRT_TMO_W   = 16;
  localparam int unsigned FRT_STAT_W  = 2;
  localparam int unsigned FRT_SLOT_W  = 3;
  localparam int unsigned FRT_EXP_W   = 4;

  localparam logic [FRT_TMO_W-1:0] FRT_TIMEOUT_RST = 16'd5000;

  localparam logic FRT_CMD_FRAG = 1'b0;
  localparam logic FRT_CMD_TICK = 1'b1;

  localparam logic [FRT_STAT_W-1:0] ST_STORED   = 2'd0;
  localparam logic [FRT_STAT_W-1:0] ST_COMPLETE = 2'd1;
  localparam logic [FRT_STAT_W-1:0] ST_DROPPED  = 2'd2;
  localparam logic [FRT_STAT_W-1:0] ST_TICK     = 2'd3;

  typedef struct packed {
    logic                  cmd;
    logic [FRT_ID_W-1:0]   src_id;
    logic [FRT_ID_W-1:0]   tag;
    logic [FRT_IDX_W-1:0]  frag_index;
    logic [FRT_IDX_W-1:0]  last_index;
    logic [FRT_FLEN_W-1:0] piece_len;
  } frt_in_t;

  typedef struct packed {
    logic [FRT_STAT_W-1:0] status;
    logic [FRT_SLOT_W-1:0] slot;
    logic [FRT_LEN_W-1:0]  total_len;
    logic [FRT_EXP_W-1:0]  expired_count;
  } frt_out_t;

  // one session record as kept in the session RAM
  typedef struct packed {
    logic [FRT_ID_W-1:0]   src_id;
    logic [FRT_ID_W-1:0]   tag;
    logic [FRT_MASK_W-1:0] mask;
    logic [FRT_LEN_W-1:0]  length;
    logic [FRT_TIME_W-1:0] start_time;
  } frt_rec_t;

endpackage

[hw/rtl/frt_stream_if.sv]
// ----------------------------------------------------------------------------
// Fragment reassembly tracker stream interface
// Valid/ready channel carrying one payload word of type T.
// ----------------------------------------------------------------------------
interface frt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/fragment_reassembly_tracker_unit.sv]
// ----------------------------------------------------------------------------
// Fragment reassembly tracker
// Session table for datagram reassembly: lookup or allocate per fragment,
// receive mask and saturating length per session, timeout on ticks.
//
//   port     dir  kind          contents
//   in_i     in   valid/ready   frt_in_t: cmd, src_id, tag, indexes, piece_len
//   out_o    out  valid/ready   frt_out_t: status, slot, total_len, expired
//   cfg_*    in   write only    timeout_ticks
//
// A bad-index fragment skips the scan, while ticks and other fragments scan
// the table: the session RAM has one read port and the scan reads one slot per
// cycle through a single key/age compare unit.
// in_i.ready is high only while idle; a finished word waits in the output
// register, so the next item is taken while out_o is stalled.
// Reset clears all sessions and time; session records need no clearing.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker_unit
  import frt_pkg::*;
#(
  parameter int unsigned SLOTS     = FRT_SLOTS,
  parameter int unsigned MAX_FRAGS = FRT_MAX_FRAGS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  frt_stream_if.sink           in_i,
  frt_stream_if.source         out_o,
  input  logic                 cfg_we_i,
  input  logic [FRT_TMO_W-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam int unsigned RecW = $bits(frt_rec_t);
  localparam logic [CntW-1:0] SlotsCnt = CntW'(SLOTS);
  localparam logic [FRT_IDX_W:0] FragLim = (FRT_IDX_W + 1)'(MAX_FRAGS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]            state_q, state_d;
  frt_in_t               item_q, item_d;
  logic [FRT_TMO_W-1:0]  timeout_q, timeout_d;
  logic [FRT_TIME_W-1:0] time_now_q, time_now_d;
  logic [SLOTS-1:0]      valid_q, valid_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]       rd_idx_q, rd_idx_d;
  logic                  hit_q, hit_d;
  logic                  free_vld_q, free_vld_d;
  logic [IdxW-1:0]       free_idx_q, free_idx_d;
  logic [FRT_EXP_W-1:0]  exp_q, exp_d;
  frt_out_t              res_q, res_d;
  logic                  out_vld_q, out_vld_d;
  frt_out_t              out_q, out_d;

  logic            ram_re, ram_we;
  logic [IdxW-1:0] ram_raddr, ram_waddr;
  frt_rec_t        ram_wdata;
  logic [RecW-1:0] ram_rdata;
  frt_rec_t        rd_rec;

  frt_ram #(
    .WIDTH (RecW),
    .DEPTH (SLOTS)
  ) u_frt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_rec = frt_rec_t'(ram_rdata);

  // shared per-slot compare unit: key match for fragments, age for ticks
  logic                  is_tick;
  logic                  slot_live;
  logic                  key_hit;
  logic [FRT_TIME_W-1:0] age;
  logic                  aged;

  assign is_tick   = (item_q.cmd == FRT_CMD_TICK);
  assign slot_live = valid_q[rd_idx_q];
  assign key_hit   = slot_live && (rd_rec.src_id == item_q.src_id)
                     && (rd_rec.tag == item_q.tag);
  assign age       = time_now_q - rd_rec.start_time;
  assign aged      = slot_live
                     && (age > {{(FRT_TIME_W - FRT_TMO_W){1'b0}}, timeout_q});

  // update path, used at most once per fragment
  logic [FRT_MASK_W-1:0] base_mask, frag_bit, new_mask, need;
  logic [FRT_LEN_W-1:0]  base_len, new_len;
  logic [FRT_LEN_W:0]    len_sum;
  logic [FRT_IDX_W-1:0]  need_sh;
  logic [IdxW-1:0]       slot_sel;
  logic                  dup, done, drop, bad_idx;

  always_comb begin
    base_mask = hit_q ? rd_rec.mask : '0;
    base_len  = hit_q ? rd_rec.length : '0;
    slot_sel  = hit_q ? rd_idx_q : free_idx_q;
    frag_bit  = FRT_MASK_W'(1) << item_q.frag_index;
    dup       = |(base_mask & frag_bit);
    new_mask  = base_mask | frag_bit;
    len_sum   = {1'b0, base_len}
                + {{(FRT_LEN_W + 1 - FRT_FLEN_W){1'b0}}, item_q.piece_len};
    new_len   = dup ? base_len : (len_sum[FRT_LEN_W] ? '1 : len_sum[FRT_LEN_W-1:0]);
    need_sh   = FRT_IDX_W'(FRT_MASK_W - 1) - item_q.last_index;
    need      = {FRT_MASK_W{1'b1}} >> need_sh;
    done      = (new_mask == need);
    drop      = !hit_q && !free_vld_q;
  end

  assign bad_idx = ({1'b0, in_i.data.frag_index} >= FragLim)
                   || ({1'b0, in_i.data.last_index} >= FragLim);

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    timeout_d  = cfg_we_i ? cfg_wdata_i : timeout_q;
    time_now_d = time_now_q;
    valid_d    = valid_q;
    cnt_d      = cnt_q;
    rd_vld_d   = rd_vld_q;
    rd_idx_d   = rd_idx_q;
    hit_d      = hit_q;
    free_vld_d = free_vld_q;
    free_idx_d = free_idx_q;
    exp_d      = exp_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    ram_re     = 1'b0;
    ram_raddr  = cnt_q[IdxW-1:0];
    ram_we     = 1'b0;
    ram_waddr  = slot_sel;
    ram_wdata  = '{src_id:     item_q.src_id,
                   tag:        item_q.tag,
                   mask:       new_mask,
                   length:     new_len,
                   start_time: hit_q ? rd_rec.start_time : time_now_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          item_d     = in_i.data;
          cnt_d      = '0;
          rd_vld_d   = 1'b0;
          hit_d      = 1'b0;
          free_vld_d = 1'b0;
          exp_d      = '0;
          if (in_i.data.cmd == FRT_CMD_TICK) begin
            time_now_d = time_now_q + FRT_TIME_W'(1);
            state_d    = S_SCAN;
          end else if (bad_idx) begin
            res_d   = '{status: ST_DROPPED, slot: '0, total_len: '0, expired_count: '0};
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // evaluate the slot read last cycle
        if (rd_vld_q) begin
          if (is_tick) begin
            if (aged) begin
              valid_d[rd_idx_q] = 1'b0;
              if (exp_q != '1) begin
                exp_d = exp_q + FRT_EXP_W'(1);
              end
            end
          end else if (!slot_live && !free_vld_q) begin
            free_vld_d = 1'b1;
            free_idx_d = rd_idx_q;
          end
        end

        if (rd_vld_q && !is_tick && key_hit) begin
          // hold read data for the update
          hit_d    = 1'b1;
          rd_vld_d = 1'b0;
          state_d  = S_UPD;
        end else if (cnt_q != SlotsCnt) begin
          ram_re   = 1'b1;
          rd_idx_d = cnt_q[IdxW-1:0];
          rd_vld_d = 1'b1;
          cnt_d    = cnt_q + CntW'(1);
        end else if (rd_vld_q) begin
          rd_vld_d = 1'b0;
        end else if (is_tick) begin
          res_d   = '{status: ST_TICK, slot: '0, total_len: '0, expired_count: exp_q};
          state_d = S_DONE;
        end else begin
          state_d = S_UPD;
        end
      end

      S_UPD: begin
        if (drop) begin
          res_d = '{status: ST_DROPPED, slot: '0, total_len: '0, expired_count: '0};
        end else begin
          ram_we            = 1'b1;
          valid_d[slot_sel] = !done;
          res_d = '{status:        done ? ST_COMPLETE : ST_STORED,
                    slot:          FRT_SLOT_W'(slot_sel),
                    total_len:     new_len,
                    expired_count: '0};
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      timeout_q  <= FRT_TIMEOUT_RST;
      time_now_q <= '0;
      valid_q    <= '0;
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
      hit_q      <= 1'b0;
      free_vld_q <= 1'b0;
      exp_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      timeout_q  <= timeout_d;
      time_now_q <= time_now_d;
      valid_q    <= valid_d;
      cnt_q      <= cnt_d;
      rd_vld_q   <= rd_vld_d;
      hit_q      <= hit_d;
      free_vld_q <= free_vld_d;
      exp_q      <= exp_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    rd_idx_q   <= rd_idx_d;
    free_idx_q <= free_idx_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

endmodule

[hw/rtl/frt_ram.sv]
// ----------------------------------------------------------------------------
// Fragment reassembly tracker generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module frt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/frt_checker.sv]
// ----------------------------------------------------------------------------
// Fragment reassembly tracker checker
// Port-level checks on the tracker, attached by bind.
// ----------------------------------------------------------------------------
`include "fragment_reassembly_tracker_unit_defines.svh"

module frt_checker
  import frt_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input frt_out_t out_data_i
);

  // a pending word stays until taken
  `FRT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "output word dropped while stalled")

  // busy after each accepted word
  `FRT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input taken while busy")

  `FRT_ASSERT_IMP(a_tick_fields, clk_i, rst_ni, out_valid_i && (out_data_i.status == ST_TICK), (out_data_i.slot == '0) && (out_data_i.total_len == '0), "tick word carries slot or length")

  `FRT_ASSERT_IMP(a_frag_fields, clk_i, rst_ni, out_valid_i && (out_data_i.status != ST_TICK), (out_data_i.expired_count == '0) && ((out_data_i.status != ST_DROPPED) || ((out_data_i.slot == '0) && (out_data_i.total_len == '0))), "fragment word fields malformed")

endmodule

bind fragment_reassembly_tracker_unit frt_checker u_frt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

[verif/fragment_reassembly_tracker_unit_test.sv]
// ----------------------------------------------------------------------------
// Fragment reassembly tracker testbench
// Drives fragment and tick words through the valid/ready input with bursty
// gaps while the output side stalls on its own pattern. A session-table
// predictor computes every result word, and each output word is compared
// field by field in order. Directed words cover table full, duplicates,
// out-of-order completion, stray mask bits and timeouts. Random datagrams are
// then sent under several timeout settings.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker_unit_test
  import frt_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LANES       = 6;

  class reassembly_predictor;
    frt_out_t                expect_q[$];
    logic [FRT_TMO_W-1:0]    timeout_ticks = FRT_TIMEOUT_RST;
    logic [FRT_TIME_W-1:0]   clock_now = '0;
    bit                      live[FRT_SLOTS] = '{default: 1'b0};
    logic [FRT_ID_W-1:0]     key_src[FRT_SLOTS];
    logic [FRT_ID_W-1:0]     key_tag[FRT_SLOTS];
    logic [FRT_MASK_W-1:0]   rx_mask[FRT_SLOTS];
    logic [FRT_LEN_W-1:0]    rx_len[FRT_SLOTS];
    logic [FRT_TIME_W-1:0]   opened_at[FRT_SLOTS];
    int unsigned             errors = 0;

    function frt_out_t note_word(frt_in_t w);
      frt_out_t           res;
      int                 hit;
      int unsigned        expired;
      logic [16:0]        sum;
      logic [16:0]        full_mask;
      res     = '0;
      hit     = -1;
      expired = 0;
      if (w.cmd == FRT_CMD_TICK) begin
        clock_now = clock_now + 32'd1;
        for (int i = 0; i < FRT_SLOTS; i++) begin
          if (live[i] && (clock_now - opened_at[i]) > {16'd0, timeout_ticks}) begin
            live[i] = 1'b0;
            if (expired < 15) expired++;
          end
        end
        res.status        = ST_TICK;
        res.expired_count = FRT_EXP_W'(expired);
      end else if (w.frag_index >= FRT_MAX_FRAGS || w.last_index >= FRT_MAX_FRAGS) begin
        res.status = ST_DROPPED;
      end else begin
        for (int i = 0; i < FRT_SLOTS && hit < 0; i++) begin
          if (live[i] && key_src[i] == w.src_id && key_tag[i] == w.tag) hit = i;
        end
        // claim the lowest free slot
        for (int i = 0; i < FRT_SLOTS && hit < 0; i++) begin
          if (!live[i]) begin
            hit          = i;
            live[i]      = 1'b1;
            key_src[i]   = w.src_id;
            key_tag[i]   = w.tag;
            rx_mask[i]   = '0;
            rx_len[i]    = '0;
            opened_at[i] = clock_now;
          end
        end
        if (hit < 0) begin
          res.status = ST_DROPPED;
        end else begin
          if (!rx_mask[hit][w.frag_index]) begin
            rx_mask[hit][w.frag_index] = 1'b1;
            sum         = {1'b0, rx_len[hit]} + 17'(w.piece_len);
            rx_len[hit] = sum[16] ? 16'hFFFF : sum[15:0];
          end
          full_mask     = (17'd1 << (w.last_index + 5'd1)) - 17'd1;
          res.slot      = FRT_SLOT_W'(hit);
          res.total_len = rx_len[hit];
          if ({1'b0, rx_mask[hit]} == full_mask) begin
            live[hit]  = 1'b0;
            res.status = ST_COMPLETE;
          end else begin
            res.status = ST_STORED;
          end
        end
      end
      expect_q.push_back(res);
      return res;
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(frt_out_t got);
      frt_out_t want;
      if (expect_q.size() == 0) begin
        $error("unexpected output word: status %0d slot %0d", got.status, got.slot);
        errors++;
        return;
      end
      want = expect_q.pop_front();
      check_field("status", want.status, got.status);
      check_field("slot", want.slot, got.slot);
      check_field("total_len", want.total_len, got.total_len);
      check_field("expired_count", want.expired_count, got.expired_count);
    endfunction

    function int unsigned pending();
      return expect_q.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [FRT_TMO_W-1:0] cfg_wdata;
  logic [11:0]          rx_phase = '0;
  int unsigned          burst_left = 0;
  int unsigned          cycle_count = 0;
  reassembly_predictor  model;

  // datagrams in flight on the sender side
  bit                   dg_live[LANES] = '{default: 1'b0};
  logic [FRT_ID_W-1:0]  dg_src[LANES];
  logic [FRT_ID_W-1:0]  dg_tag[LANES];
  logic [FRT_IDX_W-1:0] dg_last[LANES];
  logic [15:0]          dg_todo[LANES];
  logic [15:0]          dg_sent[LANES];
  int unsigned          dg_retry[LANES];

  frt_stream_if #(.T(frt_in_t))  in_if ();
  frt_stream_if #(.T(frt_out_t)) out_if ();

  fragment_reassembly_tracker_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if.sink),
    .out_o       (out_if.source),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // receiver: free-running, light random, sparse and long stalls in turn
  always @(negedge clk_i) begin
    rx_phase <= rx_phase + 12'd1;
    case (rx_phase[9:8])
      2'd0: begin
        out_if.ready <= 1'b1;
      end
      2'd1: begin
        out_if.ready <= ($urandom_range(2) != 0);
      end
      2'd2: begin
        out_if.ready <= (rx_phase[2:0] == 3'd0);
      end
      default: begin
        out_if.ready <= (rx_phase[4:0] > 5'd20);
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) model.check_report(out_if.data);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic issue(input frt_in_t w, output frt_out_t r);
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    r = model.note_word(w);
    if (burst_left == 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat ($urandom_range(8)) @(negedge clk_i);
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(80, 40) : $urandom_range(12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_frag(input logic [15:0] src, input logic [15:0] tg,
                           input logic [3:0] fidx, input logic [3:0] lidx,
                           input logic [10:0] len);
    frt_in_t  w;
    frt_out_t r;
    w            = '0;
    w.cmd        = FRT_CMD_FRAG;
    w.src_id     = src;
    w.tag        = tg;
    w.frag_index = fidx;
    w.last_index = lidx;
    w.piece_len  = len;
    issue(w, r);
  endtask

  task automatic send_tick();
    frt_in_t  w;
    frt_out_t r;
    w            = '0;
    w.cmd        = FRT_CMD_TICK;
    w.src_id     = 16'($urandom());
    w.tag        = 16'($urandom());
    w.frag_index = 4'($urandom());
    w.last_index = 4'($urandom());
    w.piece_len  = 11'($urandom());
    issue(w, r);
  endtask

  // hold off until every result word is back
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [FRT_TMO_W-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    model.timeout_ticks = value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [10:0] pick_len();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 11'd0;
    if (r == 1) return 11'h7FF;
    return 11'($urandom());
  endfunction

  function automatic logic [3:0] pick_bit(logic [15:0] m);
    int unsigned start;
    start = $urandom_range(15);
    for (int k = 0; k < 16; k++) begin
      if (m[(start + k) % 16]) return 4'((start + k) % 16);
    end
    return 4'd0;
  endfunction

  task automatic open_datagram(input int unsigned max_live);
    int unsigned n;
    int          j;
    bit          clash;
    n = 0;
    j = -1;
    for (int i = 0; i < LANES; i++) begin
      if (dg_live[i]) n++;
      else if (j < 0 && i < max_live) j = i;
    end
    if (j < 0 || n >= max_live) return;
    // keep keys distinct so two datagrams never share a session
    do begin
      clash = 1'b0;
      if ($urandom_range(1) == 0) begin
        dg_src[j] = 16'($urandom());
        dg_tag[j] = 16'($urandom());
      end else begin
        dg_src[j] = 16'($urandom_range(3));
        dg_tag[j] = 16'($urandom_range(3));
      end
      for (int i = 0; i < LANES; i++) begin
        if (dg_live[i] && dg_src[i] == dg_src[j] && dg_tag[i] == dg_tag[j]) clash = 1'b1;
      end
    end while (clash);
    dg_last[j]  = ($urandom_range(99) < 15) ? 4'($urandom_range(15)) : 4'($urandom_range(4));
    dg_todo[j]  = 16'((17'd1 << (dg_last[j] + 5'd1)) - 17'd1);
    dg_sent[j]  = '0;
    dg_retry[j] = 0;
    dg_live[j]  = 1'b1;
  endtask

  task automatic random_word(input int unsigned tick_pct, input int unsigned noise_pct,
                             input int unsigned max_live);
    frt_in_t     w;
    frt_out_t    r;
    int unsigned roll;
    int          j;
    int unsigned n;
    bit          dup;
    roll = $urandom_range(99);
    if (roll < tick_pct) begin
      send_tick();
    end else if (roll < tick_pct + noise_pct) begin
      send_frag(16'($urandom()), 16'($urandom()), 4'($urandom()), 4'($urandom()), pick_len());
    end else begin
      n = 0;
      for (int i = 0; i < LANES; i++) if (dg_live[i]) n++;
      if (n == 0 || $urandom_range(99) < 30) open_datagram(max_live);
      j = -1;
      while (j < 0) begin
        n = $urandom_range(LANES - 1);
        if (dg_live[n]) j = n;
      end
      dup          = (dg_sent[j] != 0 && $urandom_range(99) < 5);
      w            = '0;
      w.cmd        = FRT_CMD_FRAG;
      w.src_id     = dg_src[j];
      w.tag        = dg_tag[j];
      w.frag_index = dup ? pick_bit(dg_sent[j]) : pick_bit(dg_todo[j]);
      w.last_index = dg_last[j];
      w.piece_len  = pick_len();
      issue(w, r);
      if (r.status == ST_DROPPED) begin
        // table full: retry the word later, give up after a few drops
        dg_retry[j]++;
        if (dg_retry[j] > 6) dg_live[j] = 1'b0;
      end else if (!dup) begin
        dg_todo[j][w.frag_index] = 1'b0;
        dg_sent[j][w.frag_index] = 1'b1;
        if (dg_todo[j] == 0) dg_live[j] = 1'b0;
      end
    end
  endtask

  task automatic random_phase(input logic [15:0] tmo, input int unsigned words,
                              input int unsigned tick_pct, input int unsigned noise_pct,
                              input int unsigned max_live);
    drain();
    write_timeout(tmo);
    repeat (words) random_word(tick_pct, noise_pct, max_live);
  endtask

  initial begin
    model        = new;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_tick();
    send_frag(16'h0000, 16'h0000, 4'd0, 4'd0, 11'd0);
    send_frag(16'hFFFF, 16'hFFFF, 4'd15, 4'd15, 11'h7FF);
    send_frag(16'hFFFF, 16'hFFFF, 4'd15, 4'd15, 11'h7FF);
    // stray high bit: mask never equals the short range
    send_frag(16'hFFFF, 16'hFFFF, 4'd3, 4'd2, 11'd5);
    send_frag(16'hA5A5, 16'h5A5A, 4'd1, 4'd1, 11'd100);
    send_frag(16'hA5A5, 16'h5A5A, 4'd0, 4'd1, 11'h7FF);
    for (int k = 1; k <= 7; k++) begin
      send_frag(16'h0100 + 16'(k), 16'h8000 | 16'(k), 4'd0, 4'd3, 11'(k * 77));
    end
    send_frag(16'h1234, 16'h4321, 4'd0, 4'd0, 11'd9);
    send_frag(16'h0103, 16'h8003, 4'd2, 4'd3, 11'd1);

    drain();
    write_timeout(16'd1);
    send_tick();
    send_tick();
    send_tick();
    send_frag(16'h00FF, 16'hFF00, 4'd0, 4'd0, 11'd1024);

    random_phase(16'hFFFF, 120, 10, 0, 4);
    random_phase(16'd1, 150, 5, 10, 5);
    random_phase(16'($urandom_range(40, 10)), 250, 10, 10, 5);
    random_phase(16'($urandom_range(65535, 1)), 150, 10, 0, 3);
    random_phase(16'd8, 200, 15, 10, 6);

    drain();
    repeat (FRT_SLOTS + 4) @(posedge clk_i);
    if (model.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
